// ===== rtl/bmw_pkg.sv =====
// Shared constants, types and helpers of the Boruvka spanning forest weight unit.
// No dependencies; every other file of the block imports it.
package bmw_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int MAX_EDGES    = 4096;
    localparam int VW  = 11;                      // vertex label width
    localparam int VAW = $clog2(MAX_VERTICES);    // vertex table address width
    localparam int EAW = $clog2(MAX_EDGES);       // edge store address width
    localparam int ECW = EAW + 1;                 // stored edge count width
    localparam int WW  = 32;                      // edge weight width
    localparam int TW  = 43;                      // total weight width
    localparam int EDW = 2 * VW + WW;             // edge store word
    localparam int CHW = WW + VW;                 // cheapest table word

    localparam logic signed [WW-1:0] NO_PICK_WEIGHT = 32'sh7FFF_FFFF;

    typedef enum logic [4:0] {
        S_LOAD, S_INIT, S_RSTART, S_RINIT, S_EREAD, S_ECHK, S_FRD, S_FCHK,
        S_GOTA, S_GOTB, S_CMPA, S_UPDA, S_UPDB, S_MSTART, S_MNEXT, S_MGOTX,
        S_MGOTP, S_MGOTY, S_FLSTART, S_FLNEXT, S_FLWR
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_INIT_PAR, OP_RSTART, OP_INIT_CH, OP_EREAD,
        OP_SET_V_A, OP_FRD, OP_FSTEP, OP_GOTA, OP_GOTB, OP_RDCH_A, OP_UPDA,
        OP_UPDB, OP_MSTART, OP_SET_V_I, OP_GOTX, OP_SET_V_P, OP_MERGE,
        OP_FLWR, OP_RESULT
    } t_op;

    typedef struct packed {
        logic i_done;
        logic e_done;
        logic hit;
        logic ne;
        logic edge_ok;
        logic merged;
        logic out_busy;
        logic acc_last;
    } t_stat;

    // vertex label 1..MAX_VERTICES to table address
    function automatic logic [VAW-1:0] lbl_addr(input logic [VW-1:0] v);
        logic [VW-1:0] d;
        d = v - VW'(1);
        return d[VAW-1:0];
    endfunction

endpackage

// ===== rtl/bmw_edge_if.sv =====
// Edge input channel: valid/ready handshake with one undirected weighted edge.
// Depends on bmw_pkg for field widths.
interface bmw_edge_if;
    import bmw_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [VW-1:0]        end_a;
    logic [VW-1:0]        end_b;
    logic signed [WW-1:0] edge_weight;
    logic                 last_edge;
    modport source (output valid, end_a, end_b, edge_weight, last_edge, input ready);
    modport sink   (input valid, end_a, end_b, edge_weight, last_edge, output ready);
endinterface

// ===== rtl/bmw_res_if.sv =====
// Result channel: valid/ready handshake carrying the forest weight and error flag.
// Depends on bmw_pkg for field widths.
interface bmw_res_if;
    import bmw_pkg::*;
    logic                 valid;
    logic                 ready;
    logic signed [TW-1:0] total_weight;
    logic                 input_error;
    modport source (output valid, total_weight, input_error, input ready);
    modport sink   (input valid, total_weight, input_error, output ready);
endinterface

// ===== rtl/boruvka_mst_weight_unit.sv =====
// Edges load one per cycle while the unit is idle; after the edge marked last the
// unit is busy with the init pass and the rounds of edge scan, merge and flatten,
// where every find step is one read of the parent table.
// The result sits in an output register, so the next graph may load while it waits.
// Depends on bmw_pkg, bmw_edge_if, bmw_res_if, bmw_ctrl and bmw_dp.
module boruvka_mst_weight_unit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [bmw_pkg::VW-1:0] i_cfg_wdata,
    bmw_edge_if.sink               i_edge,
    bmw_res_if.source              o_res
);
    import bmw_pkg::*;

    t_op   op;
    t_stat stat;

    bmw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_op    (op)
    );

    bmw_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_op        (op),
        .o_stat      (stat),
        .i_edge      (i_edge),
        .o_res       (o_res)
    );

    a_result_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (op == OP_RESULT) |-> (!stat.merged && !stat.out_busy))
        else $error("result issued mid-round or over a pending result");

    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_edge.valid && i_edge.ready && i_edge.last_edge) |=> !i_edge.ready)
        else $error("edge taken during computation");

endmodule

// ===== rtl/bmw_ctrl.sv =====
// Sequencer of the Boruvka unit: load, init, edge scan, merge and flatten phases.
// Depends on bmw_pkg; drives one datapath operation per cycle.
module bmw_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bmw_pkg::t_stat i_stat,
    output bmw_pkg::t_op   o_op
);
    import bmw_pkg::*;

    t_state r_state, n_state;
    t_state r_ret, n_ret;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_ret   <= S_LOAD;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        unique case (r_state)
            S_LOAD:    if (i_stat.acc_last) n_state = S_INIT;
            S_INIT:    if (i_stat.i_done) n_state = S_RSTART;
            S_RSTART:  n_state = S_RINIT;
            S_RINIT:   if (i_stat.i_done) n_state = S_EREAD;
            S_EREAD:   n_state = i_stat.e_done ? S_MSTART : S_ECHK;
            S_ECHK: begin
                if (i_stat.edge_ok) begin
                    n_state = S_FRD;
                    n_ret   = S_GOTA;
                end else begin
                    n_state = S_EREAD;
                end
            end
            S_FRD:     n_state = S_FCHK;
            S_FCHK:    n_state = i_stat.hit ? r_ret : S_FRD;
            S_GOTA: begin
                n_state = S_FRD;
                n_ret   = S_GOTB;
            end
            S_GOTB:    n_state = S_CMPA;
            S_CMPA:    n_state = i_stat.ne ? S_UPDA : S_EREAD;
            S_UPDA:    n_state = S_UPDB;
            S_UPDB:    n_state = S_EREAD;
            S_MSTART:  n_state = S_MNEXT;
            S_MNEXT: begin
                if (i_stat.i_done) begin
                    n_state = S_FLSTART;
                end else begin
                    n_state = S_FRD;
                    n_ret   = S_MGOTX;
                end
            end
            S_MGOTX:   n_state = S_MGOTP;
            S_MGOTP: begin
                n_state = S_FRD;
                n_ret   = S_MGOTY;
            end
            S_MGOTY:   n_state = S_MNEXT;
            S_FLSTART: n_state = S_FLNEXT;
            S_FLNEXT: begin
                if (!i_stat.i_done) begin
                    n_state = S_FRD;
                    n_ret   = S_FLWR;
                end else if (i_stat.merged) begin
                    n_state = S_RSTART;
                end else if (!i_stat.out_busy) begin
                    n_state = S_LOAD;
                end
            end
            S_FLWR:    n_state = S_FLNEXT;
            default:   n_state = S_LOAD;
        endcase
    end

    always_comb begin
        o_op = OP_NONE;
        unique case (r_state)
            S_LOAD:    o_op = OP_LOAD;
            S_INIT:    o_op = i_stat.i_done ? OP_NONE : OP_INIT_PAR;
            S_RSTART:  o_op = OP_RSTART;
            S_RINIT:   o_op = i_stat.i_done ? OP_NONE : OP_INIT_CH;
            S_EREAD:   o_op = i_stat.e_done ? OP_NONE : OP_EREAD;
            S_ECHK:    o_op = i_stat.edge_ok ? OP_SET_V_A : OP_NONE;
            S_FRD:     o_op = OP_FRD;
            S_FCHK:    o_op = i_stat.hit ? OP_NONE : OP_FSTEP;
            S_GOTA:    o_op = OP_GOTA;
            S_GOTB:    o_op = OP_GOTB;
            S_CMPA:    o_op = i_stat.ne ? OP_RDCH_A : OP_NONE;
            S_UPDA:    o_op = OP_UPDA;
            S_UPDB:    o_op = OP_UPDB;
            S_MSTART:  o_op = OP_MSTART;
            S_MNEXT:   o_op = i_stat.i_done ? OP_NONE : OP_SET_V_I;
            S_MGOTX:   o_op = OP_GOTX;
            S_MGOTP:   o_op = OP_SET_V_P;
            S_MGOTY:   o_op = OP_MERGE;
            S_FLSTART: o_op = OP_MSTART;
            S_FLNEXT: begin
                if (!i_stat.i_done) o_op = OP_SET_V_I;
                else if (!i_stat.merged && !i_stat.out_busy) o_op = OP_RESULT;
                else o_op = OP_NONE;
            end
            S_FLWR:    o_op = OP_FLWR;
            default:   o_op = OP_NONE;
        endcase
    end

endmodule

// ===== rtl/bmw_dp.sv =====
// Datapath of the Boruvka unit: edge store, parent and cheapest tables, counters,
// running total and result register. Depends on bmw_pkg and both channel interfaces.
module bmw_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [bmw_pkg::VW-1:0] i_cfg_wdata,
    input  bmw_pkg::t_op       i_op,
    output bmw_pkg::t_stat     o_stat,
    bmw_edge_if.sink           i_edge,
    bmw_res_if.source          o_res
);
    import bmw_pkg::*;

    logic [EDW-1:0] edge_mem [MAX_EDGES];
    logic [VW-1:0]  par_mem  [MAX_VERTICES];
    logic [CHW-1:0] ch_mem   [MAX_VERTICES];

    logic [EDW-1:0] r_edge_q;
    logic [VW-1:0]  r_par_q;
    logic [CHW-1:0] r_ch_q;

    logic [ECW-1:0] r_cnt;
    logic           r_err;
    logic [VW-1:0]  r_vc;
    logic [VW-1:0]  r_nv;
    logic [VW-1:0]  r_i;
    logic [ECW-1:0] r_e;
    logic [VW-1:0]  r_v;
    logic [VW-1:0]  r_ra;
    logic [VW-1:0]  r_rb;
    logic signed [WW-1:0] r_cw;
    logic signed [TW-1:0] r_total;
    logic           r_merged;
    logic           r_out_valid;
    logic signed [TW-1:0] r_out_total;
    logic           r_out_err;

    logic [VW-1:0]  nv_now;
    logic           accept, in_ok;
    logic [VW-1:0]  q_a, q_b;
    logic signed [WW-1:0] q_w, ch_w;
    logic [VW-1:0]  ch_p;
    logic           lt;
    logic           par_we;
    logic [VAW-1:0] par_wa;
    logic [VW-1:0]  par_wd;
    logic           ch_we;
    logic [VAW-1:0] ch_wa, ch_ra;
    logic [CHW-1:0] ch_wd;
    logic           ch_re;

    assign nv_now = (r_vc > VW'(MAX_VERTICES)) ? VW'(MAX_VERTICES) : r_vc;
    assign i_edge.ready = (i_op == OP_LOAD) && i_rst_n;
    assign accept = i_edge.ready && i_edge.valid;
    assign in_ok = (i_edge.end_a != '0) && (i_edge.end_a <= nv_now)
                && (i_edge.end_b != '0) && (i_edge.end_b <= nv_now)
                && (r_cnt < ECW'(MAX_EDGES));

    assign q_a  = r_edge_q[EDW-1 -: VW];
    assign q_b  = r_edge_q[WW +: VW];
    assign q_w  = r_edge_q[WW-1:0];
    assign ch_w = r_ch_q[CHW-1 -: WW];
    assign ch_p = r_ch_q[VW-1:0];
    assign lt   = q_w < ch_w;

    assign o_stat.i_done   = r_i > r_nv;
    assign o_stat.e_done   = r_e >= r_cnt;
    assign o_stat.hit      = r_par_q == r_v;
    assign o_stat.ne       = r_ra != r_rb;
    assign o_stat.edge_ok  = (q_a != '0) && (q_a <= r_nv) && (q_b != '0) && (q_b <= r_nv);
    assign o_stat.merged   = r_merged;
    assign o_stat.out_busy = r_out_valid;
    assign o_stat.acc_last = accept && i_edge.last_edge;

    assign o_res.valid        = r_out_valid;
    assign o_res.total_weight = r_out_total;
    assign o_res.input_error  = r_out_err;

    // edge store
    always_ff @(posedge i_clk) begin
        if (accept && in_ok) begin
            edge_mem[r_cnt[EAW-1:0]] <= {i_edge.end_a, i_edge.end_b, i_edge.edge_weight};
        end
        if (i_op == OP_EREAD) begin
            r_edge_q <= edge_mem[r_e[EAW-1:0]];
        end
    end

    always_comb begin
        par_we = 1'b0;
        par_wa = lbl_addr(r_i);
        par_wd = r_i;
        unique case (i_op)
            OP_INIT_PAR: par_we = 1'b1;
            OP_MERGE: begin
                par_we = r_ra != r_v;
                par_wa = lbl_addr(r_ra);
                par_wd = r_v;
            end
            OP_FLWR: begin
                par_we = 1'b1;
                par_wd = r_v;
            end
            default: par_we = 1'b0;
        endcase
    end

    // parent table
    always_ff @(posedge i_clk) begin
        if (par_we) par_mem[par_wa] <= par_wd;
        if (i_op == OP_FRD) r_par_q <= par_mem[lbl_addr(r_v)];
    end

    always_comb begin
        ch_we = 1'b0;
        ch_wa = lbl_addr(r_i);
        ch_wd = {NO_PICK_WEIGHT, r_i};
        ch_re = 1'b0;
        ch_ra = lbl_addr(r_ra);
        unique case (i_op)
            OP_INIT_CH: ch_we = 1'b1;
            OP_RDCH_A:  ch_re = 1'b1;
            OP_UPDA: begin
                ch_we = lt;
                ch_wa = lbl_addr(r_ra);
                ch_wd = {q_w, r_rb};
                ch_re = 1'b1;
                ch_ra = lbl_addr(r_rb);
            end
            OP_UPDB: begin
                ch_we = lt;
                ch_wa = lbl_addr(r_rb);
                ch_wd = {q_w, r_ra};
            end
            OP_GOTX: begin
                ch_re = 1'b1;
                ch_ra = lbl_addr(r_v);
            end
            default: ch_we = 1'b0;
        endcase
    end

    // cheapest weight and partner per root
    always_ff @(posedge i_clk) begin
        if (ch_we) ch_mem[ch_wa] <= ch_wd;
        if (ch_re) r_ch_q <= ch_mem[ch_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_err       <= 1'b0;
            r_vc        <= VW'(MAX_VERTICES);
            r_merged    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_vc <= i_cfg_wdata;
            if (o_res.ready && r_out_valid) r_out_valid <= 1'b0;
            unique case (i_op)
                OP_LOAD: begin
                    if (accept) begin
                        if (in_ok) r_cnt <= r_cnt + ECW'(1);
                        else r_err <= 1'b1;
                        if (i_edge.last_edge) begin
                            r_nv    <= nv_now;
                            r_i     <= VW'(1);
                            r_total <= '0;
                        end
                    end
                end
                OP_INIT_PAR, OP_INIT_CH, OP_FLWR: r_i <= r_i + VW'(1);
                OP_RSTART: begin
                    r_i      <= VW'(1);
                    r_e      <= '0;
                    r_merged <= 1'b0;
                end
                OP_EREAD:   r_e <= r_e + ECW'(1);
                OP_SET_V_A: r_v <= q_a;
                OP_FSTEP:   r_v <= r_par_q;
                OP_GOTA: begin
                    r_ra <= r_v;
                    r_v  <= q_b;
                end
                OP_GOTB:    r_rb <= r_v;
                OP_MSTART:  r_i <= VW'(1);
                OP_SET_V_I: r_v <= r_i;
                OP_GOTX:    r_ra <= r_v;
                OP_SET_V_P: begin
                    r_v  <= ch_p;
                    r_cw <= ch_w;
                end
                OP_MERGE: begin
                    // join only roots that are still apart
                    if (r_ra != r_v) begin
                        r_merged <= 1'b1;
                        r_total  <= r_total + TW'(r_cw);
                    end
                    r_i <= r_i + VW'(1);
                end
                OP_RESULT: begin
                    r_out_valid <= 1'b1;
                    r_out_total <= r_total;
                    r_out_err   <= r_err;
                    r_cnt       <= '0;
                    r_err       <= 1'b0;
                end
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== test/tb_boruvka_mst_weight_unit.sv =====
// Testbench of the Boruvka spanning forest weight unit: loads random and directed graphs,
// predicts each forest weight and error flag, and compares every result transaction.
// Depends on bmw_pkg, bmw_edge_if, bmw_res_if and boruvka_mst_weight_unit.
module tb_boruvka_mst_weight_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import bmw_pkg::*;

    typedef struct {
        logic signed [TW-1:0] total_weight;
        logic                 input_error;
    } t_forest;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [VW-1:0] i_cfg_wdata = '0;

    bmw_edge_if edge_ch();
    bmw_res_if  res_ch();

    boruvka_mst_weight_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_edge     (edge_ch.sink),
        .o_res      (res_ch.source)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor state
    logic [VW-1:0]        graph_a[MAX_EDGES];
    logic [VW-1:0]        graph_b[MAX_EDGES];
    logic signed [WW-1:0] graph_w[MAX_EDGES];
    int                   graph_edges = 0;
    bit                   graph_err = 1'b0;
    int                   vcount = 1024;
    int                   parent[MAX_VERTICES+1];
    longint               best_w[MAX_VERTICES+1];
    int                   best_p[MAX_VERTICES+1];

    t_forest forest_q[$];
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    bit      failed = 1'b0;
    int      quiet_cycles = 0;

    function automatic int find_root(int v);
        int r;
        int nx;
        r = v;
        while (parent[r] != r) r = parent[r];
        while (parent[v] != r) begin
            nx = parent[v];
            parent[v] = r;
            v = nx;
        end
        return r;
    endfunction

    function automatic longint forest_weight(int nv);
        longint total;
        bit merged;
        int ra, rb, x, y;
        total = 0;
        for (int i = 1; i <= nv; i++) parent[i] = i;
        do begin
            merged = 1'b0;
            for (int i = 1; i <= nv; i++) begin
                best_p[i] = i;
                best_w[i] = 64'sd2147483647;
            end
            for (int i = 0; i < graph_edges; i++) begin
                if (graph_a[i] < 1 || graph_a[i] > nv || graph_b[i] < 1 || graph_b[i] > nv)
                    continue;
                ra = find_root(graph_a[i]);
                rb = find_root(graph_b[i]);
                if (ra == rb) continue;
                if (longint'(graph_w[i]) < best_w[ra]) begin
                    best_w[ra] = graph_w[i];
                    best_p[ra] = rb;
                end
                if (longint'(graph_w[i]) < best_w[rb]) begin
                    best_w[rb] = graph_w[i];
                    best_p[rb] = ra;
                end
            end
            for (int i = 1; i <= nv; i++) begin
                x = find_root(i);
                y = find_root(best_p[x]);
                if (x != y) begin
                    merged = 1'b1;
                    total += best_w[x];
                    parent[x] = y;
                end
            end
            for (int i = 1; i <= nv; i++) void'(find_root(i));
        end while (merged);
        return total;
    endfunction

    // accept one edge into the predictor
    function automatic void predict_edge(logic [VW-1:0] a, logic [VW-1:0] b,
                                         logic signed [WW-1:0] w, logic last);
        int nv;
        t_forest f;
        nv = (vcount > MAX_VERTICES) ? MAX_VERTICES : vcount;
        if (a < 1 || a > nv || b < 1 || b > nv || graph_edges >= MAX_EDGES) begin
            graph_err = 1'b1;
        end else begin
            graph_a[graph_edges] = a;
            graph_b[graph_edges] = b;
            graph_w[graph_edges] = w;
            graph_edges++;
        end
        if (last) begin
            f.total_weight = TW'(forest_weight(nv));
            f.input_error = graph_err;
            forest_q.push_back(f);
            graph_edges = 0;
            graph_err = 1'b0;
        end
    endfunction

    initial begin
        edge_ch.valid = 1'b0;
        edge_ch.end_a = '0;
        edge_ch.end_b = '0;
        edge_ch.edge_weight = '0;
        edge_ch.last_edge = 1'b0;
        res_ch.ready = 1'b0;
    end

    // result checker and receiver stall
    always @(posedge i_clk) begin
        t_forest exp_f;
        if (res_ch.valid && res_ch.ready) begin
            if (forest_q.size() == 0) begin
                $error("result transaction with no expectation");
                failed = 1'b1;
            end else begin
                exp_f = forest_q.pop_front();
                if (res_ch.total_weight !== exp_f.total_weight) begin
                    $error("total_weight expected %0d actual %0d",
                           exp_f.total_weight, res_ch.total_weight);
                    failed = 1'b1;
                end
                if (res_ch.input_error !== exp_f.input_error) begin
                    $error("input_error expected %0d actual %0d",
                           exp_f.input_error, res_ch.input_error);
                    failed = 1'b1;
                end
            end
        end
        res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog: the slowest graph at full size runs long, so the quiet limit is generous
    always @(posedge i_clk) begin
        if ((edge_ch.valid && edge_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000000) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // valid stays high after a transaction; drop it while idling or before a pause
    task automatic send_edge(logic [VW-1:0] a, logic [VW-1:0] b,
                             logic signed [WW-1:0] w, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            edge_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        edge_ch.valid <= 1'b1;
        edge_ch.end_a <= a;
        edge_ch.end_b <= b;
        edge_ch.edge_weight <= w;
        edge_ch.last_edge <= last;
        do @(posedge i_clk); while (!edge_ch.ready);
        predict_edge(a, b, w, last);
    endtask

    // drain results, allow the block to go idle, then write the vertex count
    task automatic set_vertices(int n);
        edge_ch.valid <= 1'b0;
        while (forest_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= VW'(n);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        vcount = n & 11'h7FF;
    endtask

    function automatic logic signed [WW-1:0] rand_weight();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $signed($urandom_range(40)) - 20;
            2: return 32'sh7FFF_FFFF;
            default: return $signed($urandom_range(1000));
        endcase
    endfunction

    task automatic test_directed();
        set_vertices(5);
        send_edge(1, 2, 32'sh8000_0000, 0);
        send_edge(2, 3, 32'sh7FFF_FFFF, 0);
        send_edge(3, 4, 7, 0);
        send_edge(4, 5, 7, 0);
        send_edge(1, 5, 7, 0);
        send_edge(0, 2, 1, 0);          // bad label
        send_edge(6, 1, 1, 0);          // above the count
        send_edge(3, 3, -4, 1);         // self loop closes the graph
        send_edge(1, 2, 3, 1);          // single edge graph
        send_edge(11'h7FF, 11'h400, 5, 1);
        set_vertices(0);                // every label bad
        send_edge(1, 1, 1, 1);
        set_vertices(11'h7FF);          // clamps to the maximum
        send_edge(1024, 1, -100, 0);
        send_edge(1023, 1024, 32'sh7FFF_FFFE, 0);
        send_edge(1025, 1, 0, 1);
        set_vertices(1);
        send_edge(1, 1, 9, 1);
        // count lowered after loading: edges beyond it are skipped silently
        set_vertices(8);
        send_edge(7, 8, -3, 0);
        send_edge(1, 2, 2, 0);
        edge_ch.valid <= 1'b0;
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= VW'(4);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        vcount = 4;
        send_edge(2, 3, 1, 1);
    endtask

    task automatic test_random(int n_items);
        int nv, len, sent;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(5))
                0: nv = 1024;
                1: nv = 2;
                default: nv = $urandom_range(3, 24);
            endcase
            set_vertices(nv);
            len = $urandom_range(1, 24);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(19) == 0)
                    send_edge(VW'($urandom), VW'($urandom), rand_weight(), k == len - 1);
                else
                    send_edge(VW'($urandom_range(1, nv)), VW'($urandom_range(1, nv)),
                              rand_weight(), k == len - 1);
                sent++;
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 33;
        recv_idle_pct = 68;
        test_directed();
        test_random(320);
        send_idle_pct = 68;
        recv_idle_pct = 33;
        test_random(320);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(300);
        edge_ch.valid <= 1'b0;
        while (forest_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (!failed)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
